// ===== rtl/ple_pkg.sv =====
package ple_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned PLACE_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [PLACE_W-1:0] PLACE_FRONT = 2'd0;
  localparam logic [PLACE_W-1:0] PLACE_BACK  = 2'd1;
  localparam logic [PLACE_W-1:0] PLACE_AT    = 2'd2;

endpackage

// ===== rtl/positional_list_engine_top.sv =====
// channel  handshake            payload
// request  in_valid / in_ready  cmd, place, position, data_in
// result   out_valid/out_ready  ok, data_out, count
//
// One request at a time. A read, or a remove of the last entry, passes through
// ST_FETCH to the result; a failing request or an insert at the end of the list
// goes straight to the result. A positional insert or remove moves every entry
// behind the position through the single memory port pair, one entry a cycle.
// rst is synchronous and empties the list; no clearing pass is needed.
// A new request is taken in the cycle the pending result is taken.
module positional_list_engine_top
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CMD_W-1:0]          cmd,
  input  logic [PLACE_W-1:0]        place,
  input  logic [POS_W-1:0]          position,
  input  logic signed [DATA_W-1:0]  data_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      ok,
  output logic signed [DATA_W-1:0]  data_out,
  output logic [COUNT_W-1:0]        count
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_SHIFT, ST_PUT, ST_RESP} state_t;

  state_t              state;
  logic [CW-1:0]       cnt;
  logic [AW-1:0]       rptr;
  logic [AW-1:0]       wptr;
  logic [CW-1:0]       rleft;
  logic                wv;
  logic [AW-1:0]       idx_r;
  logic [DATA_W-1:0]   val_r;
  logic                ins_r;
  logic                rd_r;
  logic                ok_r;
  logic [DATA_W-1:0]   data_r;

  logic [DATA_W-1:0]   mem [CAPACITY];
  logic [DATA_W-1:0]   rdata;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic [AW-1:0]       mem_raddr;

  logic                accept;
  logic                op_known;
  logic                is_ins;
  logic                full;
  logic                empty;
  logic                pos_bad;
  logic                fail;
  logic                at_end;
  logic [PW-1:0]       pos_w;
  logic [PW-1:0]       cnt_w;
  logic [PW-1:0]       idx_w;
  logic [AW-1:0]       idx_a;

  assign in_ready  = (state == ST_IDLE) || ((state == ST_RESP) && out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == ST_RESP);
  assign ok        = ok_r;
  assign data_out  = data_r;
  assign count     = COUNT_W'(cnt);

  // request decode against the current count
  always_comb begin
    pos_w    = PW'(position);
    cnt_w    = PW'(cnt);
    is_ins   = (cmd == CMD_INSERT);
    op_known = (cmd == CMD_INSERT || cmd == CMD_REMOVE || cmd == CMD_READ) &&
               (place == PLACE_FRONT || place == PLACE_BACK || place == PLACE_AT);
    full     = (cnt_w >= PW'(CAPACITY));
    empty    = (cnt == '0);
    case (place)
      PLACE_FRONT: idx_w = '0;
      PLACE_BACK:  idx_w = is_ins ? cnt_w : cnt_w - PW'(1);
      default:     idx_w = pos_w - PW'(1);
    endcase
    pos_bad = (place == PLACE_AT) &&
              ((pos_w == '0) || (pos_w > (is_ins ? cnt_w + PW'(1) : cnt_w)));
    fail    = !op_known || (is_ins ? full : empty) || pos_bad;
    idx_a   = idx_w[AW-1:0];
    at_end  = (idx_w == cnt_w);
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wptr;
    mem_wdata = rdata;
    mem_raddr = rptr;
    case (state)
      ST_IDLE, ST_RESP: begin
        mem_raddr = idx_a;
        if (accept && !fail && is_ins && at_end) begin
          mem_we    = 1'b1;
          mem_waddr = idx_a;
          mem_wdata = data_in;
        end
      end
      ST_SHIFT: mem_we = wv;
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = val_r;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      wv    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE, ST_RESP: begin
          if (state == ST_RESP && out_ready) begin
            state <= ST_IDLE;
          end
          if (accept) begin
            idx_r <= idx_a;
            val_r <= data_in;
            ins_r <= is_ins;
            rd_r  <= (cmd == CMD_READ);
            if (fail) begin
              ok_r   <= 1'b0;
              data_r <= '0;
              state  <= ST_RESP;
            end else if (is_ins && at_end) begin
              cnt    <= cnt + CW'(1);
              ok_r   <= 1'b1;
              data_r <= '0;
              state  <= ST_RESP;
            end else if (is_ins) begin
              // move entries idx..cnt-1 up one place, top first
              rptr  <= AW'(cnt - CW'(1));
              wptr  <= AW'(cnt);
              rleft <= CW'(cnt_w - idx_w);
              wv    <= 1'b0;
              state <= ST_SHIFT;
            end else begin
              state <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          ok_r   <= 1'b1;
          data_r <= rdata;
          if (rd_r) begin
            state <= ST_RESP;
          end else if (cnt - CW'(1) == CW'(idx_r)) begin
            cnt   <= cnt - CW'(1);
            state <= ST_RESP;
          end else begin
            // close the gap: entries idx+1..cnt-1 move down one place
            rptr  <= idx_r + AW'(1);
            wptr  <= idx_r;
            rleft <= cnt - CW'(1) - CW'(idx_r);
            wv    <= 1'b0;
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          // read one ahead, write the entry fetched last cycle
          wv <= (rleft != '0);
          if (rleft != '0) begin
            rptr  <= ins_r ? rptr - AW'(1) : rptr + AW'(1);
            rleft <= rleft - CW'(1);
          end
          if (wv) begin
            wptr <= ins_r ? wptr - AW'(1) : wptr + AW'(1);
          end
          if (rleft == '0) begin
            if (ins_r) begin
              state <= ST_PUT;
            end else begin
              cnt   <= cnt - CW'(1);
              state <= ST_RESP;
            end
          end
        end
        ST_PUT: begin
          cnt    <= cnt + CW'(1);
          ok_r   <= 1'b1;
          data_r <= '0;
          state  <= ST_RESP;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ple_checker.sv =====
module ple_checker
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      ok,
  input logic signed [DATA_W-1:0]  data_out,
  input logic [COUNT_W-1:0]        count
);

  // a taken request either answers at once or blocks new requests
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready || out_valid)
    else $error("new request possible while previous one still in work");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> data_out == '0)
    else $error("failed request returned nonzero data");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= CAPACITY)
    else $error("count above capacity");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(data_out) &&
                               $stable(count))
    else $error("stalled result changed");

endmodule

bind positional_list_engine_top ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .ok        (ok),
  .data_out  (data_out),
  .count     (count)
);

// ===== bench/testbench.sv =====
module testbench;
  import ple_pkg::*;

  localparam logic [CMD_W-1:0]   CMD_BAD      = 2'd3;
  localparam logic [PLACE_W-1:0] PLACE_BAD    = 2'd3;
  localparam int                 RANDOM_COUNT = 1030;
  localparam int                 STALL_LIMIT  = 3000;
  localparam int                 DRAIN_CYCLES = 80;
  localparam int                 HOLD_CYCLES  = 300;
  localparam int                 HOLD_AFTER   = 250;
  localparam int                 PRINT_MAX    = 50;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       level;
  } list_result_t;

  class list_scoreboard;
    logic signed [DATA_W-1:0] slots [CAPACITY_DEF];
    int unsigned              fill;
    list_result_t             pending [$];
    int                       errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    task flag_mismatch(string msg);
      if (errors < PRINT_MAX) $display("mismatch: %s", msg);
      errors++;
    endtask

    // apply one accepted request to the shadow list, queue what it returns
    function void note_request(logic [CMD_W-1:0] c, logic [PLACE_W-1:0] p,
                               logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] d);
      list_result_t want;
      int unsigned  spot;
      logic         good;
      want.ok = 1'b0;
      want.data = '0;
      good = 1'b0;
      spot = 0;
      if (c == CMD_INSERT && p != PLACE_BAD) begin
        if (fill < CAPACITY_DEF) begin
          case (p)
            PLACE_FRONT: begin
              spot = 0;
              good = 1'b1;
            end
            PLACE_BACK: begin
              spot = fill;
              good = 1'b1;
            end
            default: begin
              good = (pos >= 1) && (pos <= fill + 1);
              spot = pos - 1;
            end
          endcase
        end
        if (good) begin
          for (int i = fill; i > spot; i--) slots[i] = slots[i-1];
          slots[spot] = d;
          fill++;
          want.ok = 1'b1;
        end
      end else if ((c == CMD_REMOVE || c == CMD_READ) && p != PLACE_BAD && fill != 0) begin
        case (p)
          PLACE_FRONT: begin
            spot = 0;
            good = 1'b1;
          end
          PLACE_BACK: begin
            spot = fill - 1;
            good = 1'b1;
          end
          default: begin
            good = (pos >= 1) && (pos <= fill);
            spot = pos - 1;
          end
        endcase
        if (good) begin
          want.ok = 1'b1;
          want.data = slots[spot];
          if (c == CMD_REMOVE) begin
            for (int i = spot; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
          end
        end
      end
      want.level = fill[COUNT_W-1:0];
      pending.push_back(want);
    endfunction

    task check_result(logic got_ok, logic signed [DATA_W-1:0] got_data,
                      logic [COUNT_W-1:0] got_level);
      list_result_t want;
      if (pending.size() == 0) begin
        flag_mismatch("result with no request outstanding");
        return;
      end
      want = pending.pop_front();
      if (got_ok !== want.ok)
        flag_mismatch($sformatf("ok %b, expected %b", got_ok, want.ok));
      if (got_data !== want.data)
        flag_mismatch($sformatf("data_out %0d, expected %0d", got_data, want.data));
      if (got_level !== want.level)
        flag_mismatch($sformatf("count %0d, expected %0d", got_level, want.level));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         cmd = CMD_INSERT;
  logic [PLACE_W-1:0]       place = PLACE_FRONT;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] data_in = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     ok;
  logic signed [DATA_W-1:0] data_out;
  logic [COUNT_W-1:0]       count;

  list_scoreboard board = new();
  int  send_streak = 0;
  int  recv_streak = 0;
  bit  filling = 1'b1;

  positional_list_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .place     (place),
    .position  (position),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .data_out  (data_out),
    .count     (count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // idle cycles before the next handshake; now and then a run with no gaps
  function automatic int draw_wait(ref int streak);
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) streak = $urandom_range(10, 40);
    return $urandom_range(0, 14);
  endfunction

  task send_request(logic [CMD_W-1:0] c, logic [PLACE_W-1:0] p,
                    logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] d);
    int gap;
    gap = draw_wait(send_streak);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    place <= p;
    position <= pos;
    data_in <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(c, p, pos, d);
  endtask

  task run_directed();
    send_request(CMD_READ,   PLACE_FRONT, 0, 0);
    send_request(CMD_REMOVE, PLACE_BACK,  0, 0);
    send_request(CMD_READ,   PLACE_AT,    1, 0);
    send_request(CMD_INSERT, PLACE_AT,    0, 5);
    send_request(CMD_INSERT, PLACE_AT,    2, 5);
    send_request(CMD_INSERT, PLACE_FRONT, 127, 32'sh7fffffff);
    send_request(CMD_INSERT, PLACE_BACK,  0, 32'sh80000000);
    send_request(CMD_INSERT, PLACE_AT,    3, -1);
    send_request(CMD_INSERT, PLACE_AT,    1, 0);
    send_request(CMD_INSERT, PLACE_AT,    2, 32'sh55aa55aa);
    send_request(CMD_READ,   PLACE_FRONT, 64, 0);
    send_request(CMD_READ,   PLACE_BACK,  0, 0);
    send_request(CMD_READ,   PLACE_AT,    5, 0);
    send_request(CMD_READ,   PLACE_AT,    6, 0);
    send_request(CMD_READ,   PLACE_AT,    0, 0);
    send_request(CMD_REMOVE, PLACE_AT,    127, 0);
    send_request(CMD_BAD,    PLACE_FRONT, 1, 7);
    send_request(CMD_INSERT, PLACE_BAD,   1, 7);
    send_request(CMD_READ,   PLACE_BAD,   1, 0);
    send_request(CMD_REMOVE, PLACE_AT,    2, 0);
    send_request(CMD_REMOVE, PLACE_FRONT, 0, 0);
    send_request(CMD_REMOVE, PLACE_BACK,  0, 0);
    send_request(CMD_REMOVE, PLACE_AT,    1, 0);
    send_request(CMD_REMOVE, PLACE_AT,    1, 0);
    send_request(CMD_REMOVE, PLACE_FRONT, 0, 0);
  endtask

  // mostly well-formed requests; alternates between filling and draining the list
  task send_random();
    logic [CMD_W-1:0]         c;
    logic [PLACE_W-1:0]       p;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] d;
    int                       r;
    int                       limit;
    if (filling && board.fill == CAPACITY_DEF && $urandom_range(0, 2) == 0) filling = 1'b0;
    if (!filling && board.fill == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
    r = $urandom_range(0, 99);
    if (filling) c = (r < 65) ? CMD_INSERT : (r < 80) ? CMD_REMOVE : CMD_READ;
    else c = (r < 20) ? CMD_INSERT : (r < 75) ? CMD_REMOVE : CMD_READ;
    r = $urandom_range(0, 3);
    p = (r == 0) ? PLACE_FRONT : (r == 1) ? PLACE_BACK : PLACE_AT;
    limit = (c == CMD_INSERT) ? board.fill + 1 : board.fill;
    if (p != PLACE_AT || limit == 0) begin
      pos = POS_W'($urandom_range(0, 127));
    end else if ($urandom_range(0, 11) == 0) begin
      if ($urandom_range(0, 1) != 0) pos = '0;
      else pos = POS_W'($urandom_range(limit + 1, 127));
    end else begin
      pos = POS_W'($urandom_range(1, limit));
    end
    case ($urandom_range(0, 39))
      0: d = 32'sh80000000;
      1: d = 32'sh7fffffff;
      2: d = 0;
      3: d = -1;
      default: d = $urandom;
    endcase
    if ($urandom_range(0, 99) < 3) begin
      c = CMD_W'($urandom_range(0, 3));
      p = PLACE_W'($urandom_range(0, 3));
    end
    send_request(c, p, pos, d);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int k = 0; k < RANDOM_COUNT; k++) send_random();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // result side; one long hold-off lets the block back up and stall requests
  initial begin
    int  stall;
    int  seen;
    bit  held;
    seen = 0;
    held = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (!held && seen == HOLD_AFTER) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_wait(recv_streak);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_result(ok, data_out, count);
      seen++;
    end
  end

  initial begin
    int idle;
    idle = 0;
    wait (rst == 1'b0);
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ple_pkg.sv
rtl/positional_list_engine_top.sv
rtl/ple_checker.sv
bench/testbench.sv
